// File: sv/yuvovl_pkg.sv
// ----------------------------------------------------------------------------
// yuvovl_pkg
// Shared types, codes and constants of the YUV 4:2:0 overlay address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package yuvovl_pkg;

  // Largest frame or image dimension; larger register values saturate to it.
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned DimW     = $clog2(MaxDim) + 1;
  localparam int unsigned PosW     = 12;
  localparam int unsigned RowW     = 12;
  localparam int unsigned AddrW    = 25;
  localparam int unsigned LenW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  typedef logic [DimW-1:0]     dim_t;
  typedef logic [PosW-1:0]     pos_t;
  typedef logic [RowW-1:0]     row_t;
  typedef logic [AddrW-1:0]    addr_t;
  typedef logic [LenW-1:0]     len_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VIDEO_WIDTH  = 3'd0,
    CFG_VIDEO_HEIGHT = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_POS_X        = 3'd4,
    CFG_POS_Y        = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_BELOW   = 2'd2
  } status_e;

  localparam dim_t ResetVideoWidth  = 13'd1920;
  localparam dim_t ResetVideoHeight = 13'd1080;
  localparam dim_t ResetImageWidth  = 13'd64;
  localparam dim_t ResetImageHeight = 13'd64;
  localparam pos_t ResetPosX        = 12'd0;
  localparam pos_t ResetPosY        = 12'd0;

  // Effective configuration, dimensions already saturated.
  typedef struct packed {
    dim_t vw;
    dim_t vh;
    dim_t iw;
    dim_t ih;
    pos_t pos_x;
    pos_t pos_y;
  } cfg_t;

  // Partial addresses handed from the pipeline to the descriptor issue stage.
  typedef struct packed {
    status_e status;
    len_t    n;
    addr_t   y_dst;
    addr_t   y_src;
    addr_t   c_dst;
    addr_t   c_src;
    addr_t   vbase_u;
    addr_t   vbase_v;
    addr_t   ibase_u;
    addr_t   ibase_v;
  } addr_set_t;

  function automatic dim_t sat_dim(input dim_t v);
    return (v > dim_t'(MaxDim)) ? dim_t'(MaxDim) : v;
  endfunction

endpackage

`default_nettype wire

// File: sv/yuv420_overlay_copy_address_generator.sv
// ----------------------------------------------------------------------------
// yuv420_overlay_copy_address_generator
// Turns overlay row numbers into Y, U and V copy descriptors for placing a
// planar YUV 4:2:0 image onto a video frame, clipped at the frame edges.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  --------------------------------
//  in       input      in_valid_i / in_stall_o   row_index_i
//  out      output     out_valid_o / out_stall_i plane, status, dst_addr,
//                                                src_addr, length, last
//  cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
//  Each row yields three descriptors on the single output channel, one per
//  cycle while out_stall_i is low; the issue stage takes the next row as the
//  V descriptor of the current one leaves. A row's first descriptor appears
//  once the row has passed stages 1 to 4 and been loaded into the issue stage.
//  Reset loads the configuration defaults and empties every stage.
//  A stall on the output holds the current descriptor; the pipeline keeps
//  filling behind it and in_stall_o rises once all four stages are occupied.
//
`default_nettype none

module yuv420_overlay_copy_address_generator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port.
  input  wire logic                           cfg_we_i,
  input  wire logic [yuvovl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire yuvovl_pkg::cfg_data_t          cfg_wdata_i,
  // Row requests.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire yuvovl_pkg::row_t               row_index_i,
  // Copy descriptors.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          plane_o,
  output logic [1:0]                          status_o,
  output yuvovl_pkg::addr_t                   dst_addr_o,
  output yuvovl_pkg::addr_t                   src_addr_o,
  output yuvovl_pkg::len_t                    length_o,
  output logic                                last_o
);

  // Effective configuration. Dimension registers above the maximum are
  // saturated here, so the datapath never sees a value above 4096.
  yuvovl_pkg::cfg_t cfg;

  yuvovl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Four-stage address pipeline. The user must write configuration only while
  // the block is empty (not enforced here), so every stage may read it directly.
  logic                  set_valid;
  logic                  set_ready;
  yuvovl_pkg::addr_set_t addr_set;

  yuvovl_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_index_i (row_index_i),
    .set_valid_o (set_valid),
    .set_ready_i (set_ready),
    .set_o       (addr_set)
  );

  // Issue stage: completes the chroma addresses, zeroes fields of rows with
  // an error status, and transfers the three descriptors in plane order.
  yuvovl_issue u_issue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_valid_i (set_valid),
    .set_ready_o (set_ready),
    .set_i       (addr_set),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .plane_o     (plane_o),
    .status_o    (status_o),
    .dst_addr_o  (dst_addr_o),
    .src_addr_o  (src_addr_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: sv/yuvovl_cfg_regs.sv
// ----------------------------------------------------------------------------
// yuvovl_cfg_regs
// Configuration register file with saturation of the dimension registers.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvovl_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [yuvovl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire yuvovl_pkg::cfg_data_t     cfg_wdata_i,
  output yuvovl_pkg::cfg_t               cfg_o
);

  yuvovl_pkg::dim_t vw_q, vh_q, iw_q, ih_q;
  yuvovl_pkg::pos_t pos_x_q, pos_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q    <= yuvovl_pkg::ResetVideoWidth;
      vh_q    <= yuvovl_pkg::ResetVideoHeight;
      iw_q    <= yuvovl_pkg::ResetImageWidth;
      ih_q    <= yuvovl_pkg::ResetImageHeight;
      pos_x_q <= yuvovl_pkg::ResetPosX;
      pos_y_q <= yuvovl_pkg::ResetPosY;
    end else if (cfg_we_i) begin
      unique case (yuvovl_pkg::cfg_idx_e'(cfg_idx_i))
        yuvovl_pkg::CFG_VIDEO_WIDTH:  vw_q    <= cfg_wdata_i;
        yuvovl_pkg::CFG_VIDEO_HEIGHT: vh_q    <= cfg_wdata_i;
        yuvovl_pkg::CFG_IMAGE_WIDTH:  iw_q    <= cfg_wdata_i;
        yuvovl_pkg::CFG_IMAGE_HEIGHT: ih_q    <= cfg_wdata_i;
        yuvovl_pkg::CFG_POS_X:        pos_x_q <= cfg_wdata_i[yuvovl_pkg::PosW-1:0];
        yuvovl_pkg::CFG_POS_Y:        pos_y_q <= cfg_wdata_i[yuvovl_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.vw    = yuvovl_pkg::sat_dim(vw_q);
    cfg_o.vh    = yuvovl_pkg::sat_dim(vh_q);
    cfg_o.iw    = yuvovl_pkg::sat_dim(iw_q);
    cfg_o.ih    = yuvovl_pkg::sat_dim(ih_q);
    cfg_o.pos_x = pos_x_q;
    cfg_o.pos_y = pos_y_q;
  end

endmodule

`default_nettype wire

// File: sv/yuvovl_pipe.sv
// ----------------------------------------------------------------------------
// yuvovl_pipe
// Four-stage pipeline: row offset, clipping, products, partial address sums.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvovl_pipe (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire yuvovl_pkg::cfg_t      cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire yuvovl_pkg::row_t      row_index_i,
  output logic                       set_valid_o,
  input  wire logic                  set_ready_i,
  output yuvovl_pkg::addr_set_t      set_o
);

  localparam int unsigned DimW = yuvovl_pkg::DimW;
  localparam int unsigned RowW = yuvovl_pkg::RowW;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic en1, en2, en3, en4;

  // A stage moves when it is empty or when the stage after it moves.
  assign en4 = !s4_valid_q || set_ready_i;
  assign en3 = !s3_valid_q || en4;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
      if (en4) s4_valid_q <= s3_valid_q;
    end
  end

  // Stage 1: frame row of this overlay row.
  yuvovl_pkg::row_t s1_row_q;
  logic [DimW-1:0]  s1_h_q;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_row_q <= row_index_i;
      s1_h_q   <= DimW'(cfg_i.pos_y) + DimW'(row_index_i);
    end
  end

  // Stage 2: clipping and status.
  logic [DimW-1:0]    sum_x, sum_y, right, bottom, n_d;
  logic [RowW-1:0]    hd_d;
  logic               outside, below;
  yuvovl_pkg::status_e status_d;

  always_comb begin
    sum_x   = DimW'(cfg_i.pos_x) + cfg_i.iw;
    sum_y   = DimW'(cfg_i.pos_y) + cfg_i.ih;
    right   = (sum_x < cfg_i.vw) ? sum_x : cfg_i.vw;
    bottom  = (sum_y < cfg_i.vh) ? sum_y : cfg_i.vh;
    n_d     = right - DimW'(cfg_i.pos_x);
    outside = (DimW'(cfg_i.pos_x) >= cfg_i.vw) || (DimW'(cfg_i.pos_y) >= cfg_i.vh);
    below   = (s1_h_q >= bottom);
    hd_d    = s1_h_q[DimW-1:1] - RowW'(cfg_i.pos_y[yuvovl_pkg::PosW-1:1]);
    priority if (outside) status_d = yuvovl_pkg::STAT_OUTSIDE;
    else if (below)       status_d = yuvovl_pkg::STAT_BELOW;
    else                  status_d = yuvovl_pkg::STAT_OK;
  end

  yuvovl_pkg::status_e s2_status_q;
  yuvovl_pkg::len_t    s2_n_q;
  yuvovl_pkg::row_t    s2_row_q, s2_h_q, s2_hd_q;

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_status_q <= status_d;
      s2_n_q      <= n_d;
      s2_row_q    <= s1_row_q;
      s2_h_q      <= s1_h_q[RowW-1:0];
      s2_hd_q     <= hd_d;
    end
  end

  // Stage 3: products. Row values only matter for in-frame rows below 4096.
  yuvovl_pkg::status_e      s3_status_q;
  yuvovl_pkg::len_t         s3_n_q;
  logic [DimW+RowW-1:0]     s3_ydst_q, s3_ysrc_q, s3_csrc_q;
  logic [DimW+RowW-2:0]     s3_cdst_q;
  logic [2*DimW-1:0]        s3_vbase_q, s3_ibase_q;

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_q) begin
      s3_status_q <= s2_status_q;
      s3_n_q      <= s2_n_q;
      s3_ydst_q   <= cfg_i.vw * s2_h_q;
      s3_ysrc_q   <= cfg_i.iw * s2_row_q;
      s3_cdst_q   <= cfg_i.vw * s2_h_q[RowW-1:1];
      s3_csrc_q   <= cfg_i.iw * s2_hd_q;
      s3_vbase_q  <= cfg_i.vw * cfg_i.vh;
      s3_ibase_q  <= cfg_i.iw * cfg_i.ih;
    end
  end

  // Stage 4: halving, column offsets and chroma plane bases.
  yuvovl_pkg::addr_t vbu, ibu;
  yuvovl_pkg::addr_set_t s4_q;

  assign vbu = s3_vbase_q[yuvovl_pkg::AddrW-1:0];
  assign ibu = s3_ibase_q[yuvovl_pkg::AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (en4 && s3_valid_q) begin
      s4_q.status  <= s3_status_q;
      s4_q.n       <= s3_n_q;
      s4_q.y_dst   <= yuvovl_pkg::AddrW'(s3_ydst_q) + yuvovl_pkg::AddrW'(cfg_i.pos_x);
      s4_q.y_src   <= yuvovl_pkg::AddrW'(s3_ysrc_q);
      s4_q.c_dst   <= yuvovl_pkg::AddrW'(s3_cdst_q[DimW+RowW-2:1])
                      + yuvovl_pkg::AddrW'(cfg_i.pos_x[yuvovl_pkg::PosW-1:1]);
      s4_q.c_src   <= yuvovl_pkg::AddrW'(s3_csrc_q[DimW+RowW-1:1]);
      s4_q.vbase_u <= vbu;
      s4_q.vbase_v <= vbu + (vbu >> 2);
      s4_q.ibase_u <= ibu;
      s4_q.ibase_v <= ibu + (ibu >> 2);
    end
  end

  assign set_valid_o = s4_valid_q;
  assign set_o       = s4_q;

endmodule

`default_nettype wire

// File: sv/yuvovl_issue.sv
// ----------------------------------------------------------------------------
// yuvovl_issue
// Descriptor issue stage: holds the three plane descriptors of one row and
// sends them out in Y, U, V order.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvovl_issue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  set_valid_i,
  output logic                       set_ready_o,
  input  wire yuvovl_pkg::addr_set_t set_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 plane_o,
  output logic [1:0]                 status_o,
  output yuvovl_pkg::addr_t          dst_addr_o,
  output yuvovl_pkg::addr_t          src_addr_o,
  output yuvovl_pkg::len_t           length_o,
  output logic                       last_o
);

  logic               valid_q, valid_d;
  yuvovl_pkg::plane_e plane_q, plane_d;
  logic               xfer, load;

  yuvovl_pkg::status_e status_q;
  yuvovl_pkg::addr_t   y_dst_q, y_src_q, u_dst_q, u_src_q, v_dst_q, v_src_q;
  yuvovl_pkg::len_t    len_y_q, len_c_q;
  logic                ok;

  assign xfer        = valid_q && !out_stall_i;
  assign set_ready_o = !valid_q || (xfer && (plane_q == yuvovl_pkg::PLANE_V));
  assign load        = set_ready_o && set_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      plane_q <= yuvovl_pkg::PLANE_Y;
    end else begin
      valid_q <= valid_d;
      plane_q <= plane_d;
    end
  end

  always_comb begin
    valid_d = valid_q;
    plane_d = plane_q;
    if (load) begin
      valid_d = 1'b1;
      plane_d = yuvovl_pkg::PLANE_Y;
    end else if (xfer) begin
      unique case (plane_q)
        yuvovl_pkg::PLANE_Y: plane_d = yuvovl_pkg::PLANE_U;
        yuvovl_pkg::PLANE_U: plane_d = yuvovl_pkg::PLANE_V;
        yuvovl_pkg::PLANE_V: begin
          plane_d = yuvovl_pkg::PLANE_Y;
          valid_d = 1'b0;
        end
        default: plane_d = yuvovl_pkg::PLANE_Y;
      endcase
    end
  end

  // Rows with a non-ok status carry zero addresses and lengths.
  assign ok = (set_i.status == yuvovl_pkg::STAT_OK);

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= set_i.status;
      y_dst_q  <= ok ? set_i.y_dst : '0;
      y_src_q  <= ok ? set_i.y_src : '0;
      u_dst_q  <= ok ? set_i.vbase_u + set_i.c_dst : '0;
      u_src_q  <= ok ? set_i.ibase_u + set_i.c_src : '0;
      v_dst_q  <= ok ? set_i.vbase_v + set_i.c_dst : '0;
      v_src_q  <= ok ? set_i.ibase_v + set_i.c_src : '0;
      len_y_q  <= ok ? set_i.n : '0;
      len_c_q  <= ok ? (set_i.n >> 1) : '0;
    end
  end

  always_comb begin
    out_valid_o = valid_q;
    plane_o     = plane_q;
    status_o    = status_q;
    last_o      = (plane_q == yuvovl_pkg::PLANE_V);
    unique case (plane_q)
      yuvovl_pkg::PLANE_Y: begin
        dst_addr_o = y_dst_q;
        src_addr_o = y_src_q;
        length_o   = len_y_q;
      end
      yuvovl_pkg::PLANE_U: begin
        dst_addr_o = u_dst_q;
        src_addr_o = u_src_q;
        length_o   = len_c_q;
      end
      default: begin
        dst_addr_o = v_dst_q;
        src_addr_o = v_src_q;
        length_o   = len_c_q;
      end
    endcase
  end

  // A new row may only replace the held one as its V descriptor leaves.
  a_load_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && valid_q) |-> (!out_stall_i && plane_q == yuvovl_pkg::PLANE_V))
    else $error("row loaded over pending descriptors");

  a_y_then_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && plane_q == yuvovl_pkg::PLANE_Y) |=>
      (valid_q && plane_q == yuvovl_pkg::PLANE_U))
    else $error("U descriptor did not follow Y");

  a_u_then_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && plane_q == yuvovl_pkg::PLANE_U) |=>
      (valid_q && plane_q == yuvovl_pkg::PLANE_V))
    else $error("V descriptor did not follow U");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != yuvovl_pkg::STAT_OK) |->
      (dst_addr_o == '0 && src_addr_o == '0 && length_o == '0))
    else $error("error descriptor with nonzero fields");

endmodule

`default_nettype wire
